>>> sv/tcgr_pkg.sv
// Shared constants for the text console glyph renderer.
// Font geometry, control character codes and configuration register indexes.
// No dependencies.
`default_nettype none

package tcgr_pkg;

    // Font geometry.
    localparam int FONT_HEIGHT = 16;
    localparam int GLYPH_SLOTS = 256;
    localparam int TAB_WIDTH   = 4;

    // Font store size and derived widths.
    localparam int FONT_DEPTH  = 4096;
    localparam int FONT_ADDR_W = $clog2(FONT_DEPTH);
    localparam int ROW_W       = (FONT_HEIGHT > 1) ? $clog2(FONT_HEIGHT) : 1;
    localparam int SPC_W       = $clog2(TAB_WIDTH + 1);

    // Field widths.
    localparam int COL_W   = 8;
    localparam int LINE_W  = 7;
    localparam int COUNT_W = 9;
    localparam int PIX_W   = 11;
    localparam int CODE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Control character codes.
    localparam logic [CODE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CODE_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CODE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CODE_W-1:0] CH_SPACE   = 8'h20;

    // Request actions.
    localparam logic ACT_FONT_WRITE = 1'b0;
    localparam logic ACT_PUT_CHAR   = 1'b1;

    // Result kinds.
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [COL_W-1:0]   RST_TEXT_COLS   = 8'd240;
    localparam logic [LINE_W-1:0]  RST_TEXT_ROWS   = 7'd66;
    localparam logic [COUNT_W-1:0] RST_GLYPH_COUNT = 9'd256;

endpackage

`default_nettype wire

>>> sv/text_console_glyph_renderer.sv
// Text console glyph renderer: cursor sequencer, font store and output stage.
// Depends on tcgr_pkg for geometry, character codes and register indexes.
// A glyph passes the scroll check, font read and pending register to the output.
// One glyph row per cycle from the font store while the pending slot is free; a glyph
// request is accepted, scroll checked and drawn row by row; a fitting tab is checked and
// drawn per space. A font write completes on acceptance; newline and carriage return pass the scroll check.
// Reset (aresetn low, synchronous) homes the cursor and loads the register defaults;
// the font store is not cleared and holds nothing valid until written.
`default_nettype none

module text_console_glyph_renderer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Request channel.
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_action,
    input  wire logic [tcgr_pkg::CODE_W-1:0]      s_char_code,
    input  wire logic [tcgr_pkg::FONT_ADDR_W-1:0] s_font_index,
    input  wire logic [7:0]                       s_font_byte,
    // Result channel.
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_kind,
    output logic                                  m_scroll_first,
    output logic [tcgr_pkg::PIX_W-1:0]            m_pixel_x,
    output logic [tcgr_pkg::PIX_W-1:0]            m_pixel_y,
    output logic [7:0]                            m_row_bits,
    output logic                                  m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DRAW
    } state_t;

    typedef enum logic [1:0] {
        MD_GLYPH,
        MD_NEWLINE,
        MD_RETURN
    } mode_t;

    // Sequencer and cursor state.
    state_t                              state_reg, state_next;
    mode_t                               mode_reg, mode_next;
    logic [tcgr_pkg::CODE_W-1:0]         code_reg, code_next;
    logic [tcgr_pkg::CODE_W-1:0]         glyph_reg, glyph_next;
    logic [tcgr_pkg::SPC_W-1:0]          spaces_reg, spaces_next;
    logic [tcgr_pkg::ROW_W-1:0]          h_reg, h_next;
    logic                                scrolled_reg, scrolled_next;
    logic [tcgr_pkg::COL_W-1:0]          col_reg, col_next;
    logic [tcgr_pkg::LINE_W-1:0]         row_reg, row_next;

    // Configuration registers.
    logic [tcgr_pkg::COL_W-1:0]          text_cols_reg;
    logic [tcgr_pkg::LINE_W-1:0]         text_rows_reg;
    logic [tcgr_pkg::COUNT_W-1:0]        glyph_count_reg;

    // Request in flight between the font store read and the output register.
    logic                                pend_reg, pend_next;
    logic                                pend_kind_reg, pend_kind_next;
    logic                                pend_scroll_reg, pend_scroll_next;
    logic [tcgr_pkg::PIX_W-1:0]          pend_x_reg, pend_x_next;
    logic [tcgr_pkg::PIX_W-1:0]          pend_y_reg, pend_y_next;
    logic                                pend_last_reg, pend_last_next;

    // Output register.
    logic                                m_valid_reg, m_valid_next;
    logic                                m_kind_reg, m_kind_next;
    logic                                m_scroll_reg, m_scroll_next;
    logic [tcgr_pkg::PIX_W-1:0]          m_x_reg, m_x_next;
    logic [tcgr_pkg::PIX_W-1:0]          m_y_reg, m_y_next;
    logic [7:0]                          m_bits_reg, m_bits_next;
    logic                                m_last_reg, m_last_next;

    // Font store.
    logic [7:0]                          font_mem [tcgr_pkg::FONT_DEPTH];
    logic [7:0]                          mem_q;
    logic                                mem_re;
    logic [tcgr_pkg::FONT_ADDR_W-1:0]    mem_raddr;

    logic                                load;
    logic                                slot_free;
    logic                                scroll;
    logic [tcgr_pkg::LINE_W-1:0]         row_dec;
    logic                                row_last;
    logic                                wrap;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_scroll_first = m_scroll_reg;
    assign m_pixel_x      = m_x_reg;
    assign m_pixel_y      = m_y_reg;
    assign m_row_bits     = m_bits_reg;
    assign m_last         = m_last_reg;

    // The pending request moves to the output register when that register frees up.
    assign load      = pend_reg && (!m_valid_reg || m_ready);
    assign slot_free = !pend_reg || load;

    // Scroll test on the current cursor row; the decrement stops at zero.
    assign scroll  = (row_reg >= text_rows_reg);
    assign row_dec = (scroll && (row_reg != '0)) ? row_reg - 1'b1 : row_reg;

    assign row_last  = (h_reg == tcgr_pkg::ROW_W'(tcgr_pkg::FONT_HEIGHT - 1));
    assign wrap      = ((9'(col_reg) + 9'd1) >= 9'(text_cols_reg));
    assign mem_raddr = tcgr_pkg::FONT_ADDR_W'(
        tcgr_pkg::FONT_ADDR_W'(glyph_reg) * tcgr_pkg::FONT_ADDR_W'(tcgr_pkg::FONT_HEIGHT)
        + tcgr_pkg::FONT_ADDR_W'(h_reg));

    // Font store: written by font requests, read one glyph row per cycle while the pending slot is free.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && (s_action == tcgr_pkg::ACT_FONT_WRITE)) begin
            font_mem[s_font_index] <= s_font_byte;
        end
        if (mem_re) begin
            mem_q <= font_mem[mem_raddr];
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        code_next        = code_reg;
        glyph_next       = glyph_reg;
        spaces_next      = spaces_reg;
        h_next           = h_reg;
        scrolled_next    = scrolled_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        pend_next        = pend_reg;
        pend_kind_next   = pend_kind_reg;
        pend_scroll_next = pend_scroll_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_last_next   = pend_last_reg;
        m_valid_next     = m_valid_reg;
        m_kind_next      = m_kind_reg;
        m_scroll_next    = m_scroll_reg;
        m_x_next         = m_x_reg;
        m_y_next         = m_y_reg;
        m_bits_next      = m_bits_reg;
        m_last_next      = m_last_reg;
        mem_re           = 1'b0;

        // Output stage: take the pending request or drain a delivered one.
        if (load) begin
            m_valid_next  = 1'b1;
            m_kind_next   = pend_kind_reg;
            m_scroll_next = pend_scroll_reg;
            m_x_next      = pend_x_reg;
            m_y_next      = pend_y_reg;
            m_bits_next   = (pend_kind_reg == tcgr_pkg::KIND_SCROLL) ? 8'h00 : mem_q;
            m_last_next   = pend_last_reg;
            pend_next     = 1'b0;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // Decode a character request; a tab that fits becomes several spaces, else a newline.
                if (s_valid && (s_action == tcgr_pkg::ACT_PUT_CHAR)) begin
                    code_next   = s_char_code;
                    spaces_next = tcgr_pkg::SPC_W'(1);
                    state_next  = ST_CHECK;
                    if (s_char_code == tcgr_pkg::CH_NEWLINE) begin
                        mode_next = MD_NEWLINE;
                    end else if (s_char_code == tcgr_pkg::CH_RETURN) begin
                        mode_next = MD_RETURN;
                    end else if (s_char_code == tcgr_pkg::CH_TAB) begin
                        if ((9'(col_reg) + 9'(tcgr_pkg::TAB_WIDTH)) <= 9'(text_cols_reg)) begin
                            mode_next   = MD_GLYPH;
                            code_next   = tcgr_pkg::CH_SPACE;
                            spaces_next = tcgr_pkg::SPC_W'(tcgr_pkg::TAB_WIDTH);
                        end else begin
                            mode_next = MD_NEWLINE;
                        end
                    end else begin
                        mode_next = MD_GLYPH;
                    end
                end
            end
            ST_CHECK: begin
                if (mode_reg == MD_GLYPH) begin
                    // Scroll if needed and pick the glyph, falling back to glyph zero.
                    row_next      = row_dec;
                    scrolled_next = scroll;
                    h_next        = '0;
                    state_next    = ST_DRAW;
                    if ((9'(code_reg) < glyph_count_reg)
                            && (9'(code_reg) < 9'(tcgr_pkg::GLYPH_SLOTS))) begin
                        glyph_next = code_reg;
                    end else begin
                        glyph_next = '0;
                    end
                end else if (!scroll || slot_free) begin
                    // Line control: a scroll gives one result of its own.
                    if (scroll) begin
                        pend_next        = 1'b1;
                        pend_kind_next   = tcgr_pkg::KIND_SCROLL;
                        pend_scroll_next = 1'b1;
                        pend_x_next      = '0;
                        pend_y_next      = '0;
                        pend_last_next   = 1'b1;
                    end
                    col_next   = '0;
                    row_next   = (mode_reg == MD_NEWLINE) ? row_dec + 1'b1 : row_dec;
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW: begin
                // Read one glyph row a cycle while the pending slot frees up.
                if (slot_free) begin
                    mem_re           = 1'b1;
                    pend_next        = 1'b1;
                    pend_kind_next   = tcgr_pkg::KIND_ROW;
                    pend_scroll_next = scrolled_reg && (h_reg == '0);
                    pend_x_next      = {col_reg, 3'b000};
                    pend_y_next      = tcgr_pkg::PIX_W'(
                        tcgr_pkg::PIX_W'(row_reg) * tcgr_pkg::PIX_W'(tcgr_pkg::FONT_HEIGHT)
                        + tcgr_pkg::PIX_W'(h_reg));
                    pend_last_next   = row_last && (spaces_reg == tcgr_pkg::SPC_W'(1));
                    h_next           = h_reg + 1'b1;
                    if (row_last) begin
                        // Advance the cursor and wrap at the end of the line.
                        if (wrap) begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                        spaces_next = spaces_reg - 1'b1;
                        state_next  = (spaces_reg == tcgr_pkg::SPC_W'(1)) ? ST_IDLE : ST_CHECK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, cursor, configuration and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            col_reg         <= '0;
            row_reg         <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            text_cols_reg   <= tcgr_pkg::RST_TEXT_COLS;
            text_rows_reg   <= tcgr_pkg::RST_TEXT_ROWS;
            glyph_count_reg <= tcgr_pkg::RST_GLYPH_COUNT;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    tcgr_pkg::REG_TEXT_COLS:   text_cols_reg   <= cfg_wdata[tcgr_pkg::COL_W-1:0];
                    tcgr_pkg::REG_TEXT_ROWS:   text_rows_reg   <= cfg_wdata[tcgr_pkg::LINE_W-1:0];
                    tcgr_pkg::REG_GLYPH_COUNT: glyph_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        mode_reg        <= mode_next;
        code_reg        <= code_next;
        glyph_reg       <= glyph_next;
        spaces_reg      <= spaces_next;
        h_reg           <= h_next;
        scrolled_reg    <= scrolled_next;
        pend_kind_reg   <= pend_kind_next;
        pend_scroll_reg <= pend_scroll_next;
        pend_x_reg      <= pend_x_next;
        pend_y_reg      <= pend_y_next;
        pend_last_reg   <= pend_last_next;
        m_kind_reg      <= m_kind_next;
        m_scroll_reg    <= m_scroll_next;
        m_x_reg         <= m_x_next;
        m_y_reg         <= m_y_next;
        m_bits_reg      <= m_bits_next;
        m_last_reg      <= m_last_next;
    end

`ifndef SYNTHESIS
    // A pending request that cannot move on is never dropped.
    a_pend_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && !load |=> pend_reg)
        else $error("pending request lost");

    // A scroll-only result carries no pixels.
    a_scroll_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_kind_reg == tcgr_pkg::KIND_SCROLL)
            |-> (m_bits_reg == 8'h00) && (m_x_reg == '0) && (m_y_reg == '0))
        else $error("scroll-only result has pixel data");

    // A scroll-only result is flagged as a scroll and ends its request.
    a_scroll_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_kind_reg == tcgr_pkg::KIND_SCROLL) |-> m_scroll_reg && m_last_reg)
        else $error("scroll-only result not marked");

    // The font store is read only while a glyph is being drawn.
    a_read_in_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> (state_reg == ST_DRAW) && slot_free)
        else $error("font read outside drawing");
`endif

endmodule

`default_nettype wire
